>>> design/tcw_pkg.sv
// Shared constants and types for the text console writer.
`default_nettype none
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  // Memory address width and counter width (a counter also holds CELLS itself)
  localparam int MA_W  = $clog2(CELLS);
  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int POS_W = 16;
  localparam int CUR_W = 11;

  // One screen cell: attribute in the high byte, character in the low byte
  typedef logic [15:0] cell_t;

  // Character and attribute codes
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] RESET_ATTR   = 8'h0F;
  localparam cell_t      RESET_CELL   = {RESET_ATTR, SPACE_CODE};

  // Action codes
  localparam logic [2:0] ACT_PUT     = 3'd0;
  localparam logic [2:0] ACT_ROW_COL = 3'd1;
  localparam logic [2:0] ACT_POS     = 3'd2;
  localparam logic [2:0] ACT_READ    = 3'd3;
  localparam logic [2:0] ACT_CLEAR   = 3'd4;

endpackage
`default_nettype wire

>>> design/text_console_writer_core.sv
// Top level of the text console writer: screen memory, cursor and action sequencer.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    action, char_code, attribute, row, column, position
//   out_     output     out_valid / out_stall  cursor_pos, cell_data, scrolled, ignored
//   cfg_     input      cfg_wr_en              cfg_wr_data (blank attribute)
//
// Each accepted word runs through the sequencer to the final state, which raises out_valid: a put,
// a cursor move or a read passes a working state first; a rejected move, an off-screen read or a
// spare code goes straight there, and the next word is taken once the result is loaded. A newline
// first walks row by row down to the cursor row, each row of overflow takes its own step, and a scroll
// then sweeps the whole screen memory through its one read and one write port (a clear always sweeps).
// After reset a clearing pass over all CELLS (2000) cells blanks the screen with in_stall high;
// cfg writes are taken. A result waiting on out_stall holds the sequencer in its final state.
`default_nettype none
module text_console_writer_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [2:0]                  in_action,
  input  wire logic [7:0]                  in_char_code,
  input  wire logic [7:0]                  in_attribute,
  input  wire logic [7:0]                  in_row,
  input  wire logic [7:0]                  in_column,
  input  wire logic [tcw_pkg::POS_W-1:0]   in_position,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [tcw_pkg::CUR_W-1:0]        out_cursor_pos,
  output tcw_pkg::cell_t                   out_cell_data,
  output logic                             out_scrolled,
  output logic                             out_ignored,
  input  wire logic                        cfg_wr_en,
  input  wire logic [7:0]                  cfg_wr_data
);
  import tcw_pkg::*;

  localparam int SRC_W = CNT_W + 1;

  localparam logic [CNT_W-1:0] CELLS_C = CNT_W'(CELLS);
  localparam logic [CNT_W-1:0] COLS_C  = CNT_W'(COLUMNS);
  localparam logic [CNT_W-1:0] SAT_C   = CNT_W'(CELLS - COLUMNS);
  localparam logic [POS_W-1:0] CELLS_P = POS_W'(CELLS);
  localparam logic [POS_W-1:0] COLS_P  = POS_W'(COLUMNS);
  localparam logic [SRC_W-1:0] CELLS_S = SRC_W'(CELLS);

  // Sequencer states
  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_NORM  = 3'd2;
  localparam logic [2:0] ST_ROWF  = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_SWEEP = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [CUR_W-1:0] cursor_r, cursor_nxt;
  logic [7:0]       blank_attr_r;
  logic [POS_W-1:0] pos_work_r, pos_work_nxt;
  logic [CNT_W-1:0] base_r, base_nxt;
  logic [CNT_W-1:0] shift_r, shift_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             wr_valid_r, wr_valid_nxt;
  logic [MA_W-1:0]  wr_addr_r, wr_addr_nxt;
  logic             wr_copy_r, wr_copy_nxt;
  cell_t            cell_r, cell_nxt;
  logic             scrolled_r, scrolled_nxt;
  logic             ignored_r, ignored_nxt;
  logic             out_valid_r;
  logic [CUR_W-1:0] out_cursor_r;
  cell_t            out_cell_r;
  logic             out_scrolled_r;
  logic             out_ignored_r;

  // Screen memory ports
  cell_t            mem [CELLS];
  logic             mem_we;
  logic [MA_W-1:0]  mem_waddr;
  cell_t            mem_wdata;
  logic             mem_re;
  logic [MA_W-1:0]  mem_raddr;
  cell_t            mem_rdata_r;

  logic [SRC_W-1:0] src;
  logic             accept;
  logic             out_load;
  cell_t            blank_cell;

  assign blank_cell = {blank_attr_r, SPACE_CODE};
  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state_r != ST_IDLE);
  assign out_load   = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign src        = SRC_W'(idx_r) + SRC_W'(shift_r);

  // Screen memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt    = state_r;
    cursor_nxt   = cursor_r;
    pos_work_nxt = pos_work_r;
    base_nxt     = base_r;
    shift_nxt    = shift_r;
    idx_nxt      = idx_r;
    wr_valid_nxt = 1'b0;
    wr_addr_nxt  = wr_addr_r;
    wr_copy_nxt  = wr_copy_r;
    cell_nxt     = cell_r;
    scrolled_nxt = scrolled_r;
    ignored_nxt  = ignored_r;
    mem_we       = 1'b0;
    mem_waddr    = wr_addr_r;
    mem_wdata    = blank_cell;
    mem_re       = 1'b0;
    mem_raddr    = in_position[MA_W-1:0];

    case (state_r)
      ST_INIT: begin
        // fill the screen with the reset blank, one cell a cycle
        mem_we    = 1'b1;
        mem_waddr = idx_r[MA_W-1:0];
        mem_wdata = RESET_CELL;
        idx_nxt   = idx_r + CNT_W'(1);
        if (idx_r == CELLS_C - CNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cell_nxt     = '0;
          scrolled_nxt = 1'b0;
          ignored_nxt  = 1'b0;
          shift_nxt    = '0;
          idx_nxt      = '0;
          case (in_action)
            ACT_PUT: begin
              if (in_char_code == NEWLINE_CODE) begin
                pos_work_nxt = POS_W'(cursor_r);
                base_nxt     = '0;
                state_nxt    = ST_ROWF;
              end else begin
                mem_we       = 1'b1;
                mem_waddr    = cursor_r[MA_W-1:0];
                mem_wdata    = {in_attribute, in_char_code};
                pos_work_nxt = POS_W'(cursor_r) + POS_W'(1);
                state_nxt    = ST_NORM;
              end
            end
            ACT_ROW_COL: begin
              if (POS_W'(in_column) >= COLS_P) begin
                ignored_nxt = 1'b1;
                state_nxt   = ST_DONE;
              end else begin
                pos_work_nxt = POS_W'(POS_W'(in_row) * COLS_P) + POS_W'(in_column);
                state_nxt    = ST_NORM;
              end
            end
            ACT_POS: begin
              pos_work_nxt = in_position;
              state_nxt    = ST_NORM;
            end
            ACT_READ: begin
              if (in_position < CELLS_P) begin
                mem_re    = 1'b1;
                state_nxt = ST_READ;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            ACT_CLEAR: begin
              cursor_nxt = '0;
              shift_nxt  = CELLS_C;
              state_nxt  = ST_SWEEP;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_ROWF: begin
        // find the start of the cursor row, then aim at the next one
        if (pos_work_r >= COLS_P) begin
          pos_work_nxt = pos_work_r - COLS_P;
          base_nxt     = base_r + COLS_C;
        end else begin
          pos_work_nxt = POS_W'(base_r) + COLS_P;
          state_nxt    = ST_NORM;
        end
      end
      ST_NORM: begin
        // pull an off-screen target back one row at a time, counting the scroll
        if (pos_work_r >= CELLS_P) begin
          pos_work_nxt = pos_work_r - COLS_P;
          shift_nxt    = (shift_r >= SAT_C) ? CELLS_C : shift_r + COLS_C;
          scrolled_nxt = 1'b1;
        end else begin
          cursor_nxt = pos_work_r[CUR_W-1:0];
          state_nxt  = (shift_r != '0) ? ST_SWEEP : ST_DONE;
        end
      end
      ST_READ: begin
        cell_nxt  = mem_rdata_r;
        state_nxt = ST_DONE;
      end
      ST_SWEEP: begin
        // issue: read the source cell, or mark the slot for a blank
        if (idx_r != CELLS_C) begin
          wr_valid_nxt = 1'b1;
          wr_addr_nxt  = idx_r[MA_W-1:0];
          wr_copy_nxt  = (src < CELLS_S);
          mem_re       = (src < CELLS_S);
          mem_raddr    = src[MA_W-1:0];
          idx_nxt      = idx_r + CNT_W'(1);
        end
        // write back in the cycle after the read; the source always lies ahead
        if (wr_valid_r) begin
          mem_we    = 1'b1;
          mem_waddr = wr_addr_r;
          mem_wdata = wr_copy_r ? mem_rdata_r : blank_cell;
        end
        if (idx_r == CELLS_C && !wr_valid_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      cursor_r     <= '0;
      blank_attr_r <= RESET_ATTR;
      idx_r        <= '0;
      wr_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cursor_r   <= cursor_nxt;
      idx_r      <= idx_nxt;
      wr_valid_r <= wr_valid_nxt;
      if (cfg_wr_en) begin
        blank_attr_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos_work_r <= pos_work_nxt;
    base_r     <= base_nxt;
    shift_r    <= shift_nxt;
    wr_addr_r  <= wr_addr_nxt;
    wr_copy_r  <= wr_copy_nxt;
    cell_r     <= cell_nxt;
    scrolled_r <= scrolled_nxt;
    ignored_r  <= ignored_nxt;
    if (out_load) begin
      out_cursor_r   <= cursor_r;
      out_cell_r     <= cell_r;
      out_scrolled_r <= scrolled_r;
      out_ignored_r  <= ignored_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_pos = out_cursor_r;
  assign out_cell_data  = out_cell_r;
  assign out_scrolled   = out_scrolled_r;
  assign out_ignored    = out_ignored_r;

`ifndef SYNTH
  // the cursor never leaves the screen
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(cursor_r) < CELLS))
    else $error("cursor left the screen");

  // a result word reports an on-screen cursor
  a_out_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_cursor_pos) < CELLS))
    else $error("result word carries an off-screen cursor");

  // during a sweep the write-back trails the read
  a_sweep_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP && mem_we && mem_re) |-> (mem_waddr < mem_raddr))
    else $error("sweep write overtook its read");

  // a new result word comes only from the final state
  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result word loaded outside the final state");
`endif

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the text console writer core.
module testbench;
  import tcw_pkg::*;

  // Action codes the block must treat as no-ops
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 8;
  localparam int ITEM_BUDGET = CELLS + (2 ** POS_W - CELLS) / COLUMNS + 2 * ROWS + 100;
  localparam int unsigned LIMIT = 4 * 2000 * ITEM_BUDGET + 2 * HOLD_CYCLES + CELLS;

  typedef struct packed {
    logic       drain_first;   // wait for every outstanding status before offering
    logic [2:0] action;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic [7:0] row;
    logic [7:0] column;
    logic [POS_W-1:0] position;
  } cmd_t;

  typedef struct packed {
    logic [CUR_W-1:0] cursor_pos;
    cell_t            cell_data;
    logic             scrolled;
    logic             ignored;
  } console_status_t;

  logic clk;
  logic rst_n = 1'b0;

  logic             in_valid     = 1'b0;
  logic             in_stall;
  logic [2:0]       in_action    = '0;
  logic [7:0]       in_char_code = '0;
  logic [7:0]       in_attribute = '0;
  logic [7:0]       in_row       = '0;
  logic [7:0]       in_column    = '0;
  logic [POS_W-1:0] in_position  = '0;
  logic             out_valid;
  logic             out_stall    = 1'b0;
  logic [CUR_W-1:0] out_cursor_pos;
  cell_t            out_cell_data;
  logic             out_scrolled;
  logic             out_ignored;
  logic             cfg_wr_en    = 1'b0;
  logic [7:0]       cfg_wr_data  = '0;

  // Pending command words and the statuses they must produce
  cmd_t            cmd_queue[$];
  console_status_t awaited_status[$];
  cmd_t            offer;

  // Shadow copy of the console state
  cell_t       shadow_screen[CELLS];
  int unsigned shadow_cursor     = 0;
  logic [7:0]  shadow_blank_attr = RESET_ATTR;

  int          idle_pct    = 0;
  int          stall_pct   = 0;
  int          holds_asked = 0;
  int          holds_done  = 0;
  int          hold_left   = 0;
  int          n_sent      = 0;
  int          n_checked   = 0;
  int          n_fail      = 0;
  int          n_scrolls   = 0;
  int          n_ignored   = 0;
  int          n_cfg       = 0;
  int unsigned cycle_count = 0;

  text_console_writer_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_char_code   (in_char_code),
    .in_attribute   (in_attribute),
    .in_row         (in_row),
    .in_column      (in_column),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cursor_pos (out_cursor_pos),
    .out_cell_data  (out_cell_data),
    .out_scrolled   (out_scrolled),
    .out_ignored    (out_ignored),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  // Blank every cell from the given index to the end of the screen
  function automatic void blank_from(int unsigned from);
    for (int unsigned i = from; i < CELLS; i++)
      shadow_screen[i] = {shadow_blank_attr, SPACE_CODE};
  endfunction

  // Scroll the screen up by a number of rows, blanking the new bottom rows
  function automatic void scroll_rows(int unsigned count);
    int unsigned shift;
    if (count == 0)
      return;
    if (count >= ROWS) begin
      blank_from(0);
      return;
    end
    shift = count * COLUMNS;
    for (int unsigned i = 0; i < CELLS - shift; i++)
      shadow_screen[i] = shadow_screen[i + shift];
    blank_from(CELLS - shift);
  endfunction

  function automatic int unsigned place_row_col(int unsigned row, int unsigned col);
    int unsigned k;
    k = 0;
    if (row >= ROWS) begin
      k = row - ROWS + 1;
      row -= k;
    end
    scroll_rows(k);
    shadow_cursor = row * COLUMNS + col;
    return k;
  endfunction

  function automatic int unsigned place_linear(int unsigned pos);
    int unsigned k;
    k = 0;
    if (pos >= CELLS) begin
      k = (pos - CELLS) / COLUMNS + 1;
      pos -= k * COLUMNS;
    end
    scroll_rows(k);
    shadow_cursor = pos;
    return k;
  endfunction

  // Apply one command word to the shadow console and return its status
  function automatic console_status_t console_apply(cmd_t c);
    console_status_t r;
    int unsigned     k;
    r = '0;
    k = 0;
    if (shadow_cursor >= CELLS)
      shadow_cursor = 0;
    case (c.action)
      ACT_PUT: begin
        if (c.char_code == NEWLINE_CODE) begin
          k = place_row_col(shadow_cursor / COLUMNS + 1, 0);
        end else begin
          shadow_screen[shadow_cursor] = {c.attribute, c.char_code};
          k = place_linear(shadow_cursor + 1);
        end
      end
      ACT_ROW_COL: begin
        if (c.column >= COLUMNS)
          r.ignored = 1'b1;
        else
          k = place_row_col(c.row, c.column);
      end
      ACT_POS: begin
        k = place_linear(c.position);
      end
      ACT_READ: begin
        if (c.position < CELLS)
          r.cell_data = shadow_screen[c.position];
      end
      ACT_CLEAR: begin
        blank_from(0);
        shadow_cursor = 0;
      end
      default: begin
      end
    endcase
    r.cursor_pos = shadow_cursor[CUR_W-1:0];
    r.scrolled   = (k != 0);
    return r;
  endfunction

  // ---------------------------------------------------------------- driver

  // Hold a stalled word, otherwise predict the accepted one and offer the next
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        awaited_status.push_back(console_apply(offer));
        n_sent++;
      end
      if (cmd_queue.size() != 0 && !(cmd_queue[0].drain_first && n_sent != n_checked) &&
          $urandom_range(0, 99) >= idle_pct) begin
        offer = cmd_queue.pop_front();
        in_valid     <= 1'b1;
        in_action    <= offer.action;
        in_char_code <= offer.char_code;
        in_attribute <= offer.attribute;
        in_row       <= offer.row;
        in_column    <= offer.column;
        in_position  <= offer.position;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result channel: a requested long hold first, else at random
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      out_stall  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------- monitor

  // Compare each accepted status word with the oldest expectation
  always @(posedge clk) begin
    console_status_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_status.size() == 0) begin
        $error("status word with none awaited: cursor_pos %0d", out_cursor_pos);
        n_fail++;
      end else begin
        want = awaited_status.pop_front();
        if (out_cursor_pos !== want.cursor_pos) begin
          $error("cursor_pos: expected %0d, got %0d", want.cursor_pos, out_cursor_pos);
          n_fail++;
        end
        if (out_cell_data !== want.cell_data) begin
          $error("cell_data: expected %04h, got %04h", want.cell_data, out_cell_data);
          n_fail++;
        end
        if (out_scrolled !== want.scrolled) begin
          $error("scrolled: expected %0b, got %0b", want.scrolled, out_scrolled);
          n_fail++;
        end
        if (out_ignored !== want.ignored) begin
          $error("ignored: expected %0b, got %0b", want.ignored, out_ignored);
          n_fail++;
        end
        n_scrolls += want.scrolled;
        n_ignored += want.ignored;
      end
      n_checked <= n_checked + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic cmd_t make_cmd(logic [2:0] act, logic [7:0] ch, logic [7:0] attr,
                                    logic [7:0] row, logic [7:0] col, logic [POS_W-1:0] pos);
    cmd_t c;
    c.drain_first = 1'b0;
    c.action      = act;
    c.char_code   = ch;
    c.attribute   = attr;
    c.row         = row;
    c.column      = col;
    c.position    = pos;
    return c;
  endfunction

  // Wait until every word is accepted and every status has arrived
  task automatic drain_all();
    while (cmd_queue.size() != 0 || in_valid || awaited_status.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_blank_attr(input logic [7:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_blank_attr = value;
    n_cfg++;
    @(negedge clk);
  endtask

  // One random phase: mostly writes and cursor moves, some reads, scrolls, clears and spare codes
  task automatic run_phase(input int count, input int idle, input int stall,
                           input bit long_hold, input logic [7:0] blank_attr);
    cmd_t c;
    int   pick;
    set_blank_attr(blank_attr);
    idle_pct  = idle;
    stall_pct = stall;
    if (long_hold)
      holds_asked++;
    for (int i = 0; i < count; i++) begin
      c = make_cmd(ACT_PUT, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   16'($urandom));
      c.drain_first = ($urandom_range(0, 49) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        if ($urandom_range(0, 9) == 0)
          c.char_code = NEWLINE_CODE;
      end else if (pick < 67) begin
        c.action = ACT_ROW_COL;
        if ($urandom_range(0, 3) != 0)
          c.row = 8'($urandom_range(0, ROWS - 1));
        if ($urandom_range(0, 4) != 0)
          c.column = 8'($urandom_range(0, COLUMNS - 1));
      end else if (pick < 77) begin
        c.action = ACT_POS;
        if ($urandom_range(0, 3) != 0)
          c.position = 16'($urandom_range(0, CELLS - 1));
      end else if (pick < 92) begin
        c.action = ACT_READ;
        if ($urandom_range(0, 5) != 0)
          c.position = 16'($urandom_range(0, CELLS - 1));
      end else if (pick < 94) begin
        c.action = ACT_CLEAR;
      end else begin
        c.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
      end
      cmd_queue.push_back(c);
    end
    drain_all();
  endtask

  initial begin
    for (int i = 0; i < CELLS; i++)
      shadow_screen[i] = RESET_CELL;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: field extremes, edge of screen, scrolls, clear, spare codes
    cmd_queue.push_back(make_cmd(ACT_PUT, 8'h41, 8'h00, 8'h00, 8'h00, 16'h0000));
    cmd_queue.push_back(make_cmd(ACT_PUT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
    cmd_queue.push_back(make_cmd(ACT_PUT, 8'h00, 8'h5A, 8'h00, 8'h00, 16'h0000));
    cmd_queue.push_back(make_cmd(ACT_READ, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0));
    cmd_queue.push_back(make_cmd(ACT_PUT, NEWLINE_CODE, 8'h07, 8'h00, 8'h00, 16'd0));
    cmd_queue.push_back(make_cmd(ACT_ROW_COL, 8'h00, 8'h00, 8'd0, 8'(COLUMNS - 1), 16'd0));
    cmd_queue.push_back(make_cmd(ACT_ROW_COL, 8'h00, 8'h00, 8'd3, 8'(COLUMNS), 16'd0));
    cmd_queue.push_back(make_cmd(ACT_ROW_COL, 8'h00, 8'h00, 8'hFF, 8'hFF, 16'd0));
    cmd_queue.push_back(make_cmd(ACT_ROW_COL, 8'h00, 8'h00, 8'(ROWS - 1), 8'(COLUMNS - 1),
                                 16'd0));
    cmd_queue.push_back(make_cmd(ACT_PUT, 8'h5A, 8'h1E, 8'h00, 8'h00, 16'd0));
    cmd_queue.push_back(make_cmd(ACT_READ, 8'h00, 8'h00, 8'h00, 8'h00,
                                 16'(CELLS - COLUMNS - 1)));
    cmd_queue.push_back(make_cmd(ACT_READ, 8'h00, 8'h00, 8'h00, 8'h00, 16'(CELLS - 1)));
    cmd_queue.push_back(make_cmd(ACT_READ, 8'h00, 8'h00, 8'h00, 8'h00, 16'(CELLS)));
    cmd_queue.push_back(make_cmd(ACT_READ, 8'h00, 8'h00, 8'h00, 8'h00, 16'hFFFF));
    cmd_queue.push_back(make_cmd(ACT_PUT, NEWLINE_CODE, 8'h00, 8'h00, 8'h00, 16'd0));
    cmd_queue.push_back(make_cmd(ACT_ROW_COL, 8'h00, 8'h00, 8'(ROWS), 8'd5, 16'd0));
    cmd_queue.push_back(make_cmd(ACT_ROW_COL, 8'h00, 8'h00, 8'hFF, 8'd0, 16'd0));
    cmd_queue.push_back(make_cmd(ACT_POS, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0));
    cmd_queue.push_back(make_cmd(ACT_POS, 8'h00, 8'h00, 8'h00, 8'h00, 16'(CELLS - 1)));
    cmd_queue.push_back(make_cmd(ACT_POS, 8'h00, 8'h00, 8'h00, 8'h00, 16'(CELLS)));
    cmd_queue.push_back(make_cmd(ACT_POS, 8'h00, 8'h00, 8'h00, 8'h00, 16'hFFFF));
    cmd_queue.push_back(make_cmd(ACT_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
    cmd_queue.push_back(make_cmd(ACT_SPARE_LO, 8'h41, 8'h07, 8'd2, 8'd2, 16'd5));
    cmd_queue.push_back(make_cmd(ACT_SPARE_HI, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
    cmd_queue.push_back(make_cmd(ACT_READ, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0));
    drain_all();

    // Random phases across blank attributes and idling patterns
    run_phase(350, 0, 0, 1'b1, 8'h00);
    run_phase(300, 76, 0, 1'b0, 8'hFF);
    run_phase(300, 0, 76, 1'b0, 8'($urandom_range(0, 255)));
    run_phase(300, 38, 38, 1'b0, 8'($urandom_range(0, 255)));
    run_phase(400, 0, 0, 1'b1, RESET_ATTR);

    // Allow for a stray late status word
    repeat (CELLS + 2 * ROWS + 16) @(negedge clk);

    $display("%0d status words checked, %0d with a scroll, %0d rejected cursor moves",
             n_checked, n_scrolls, n_ignored);
    $display("blank attribute written %0d times, %0d long receiver holds", n_cfg, holds_done);
    if (n_fail == 0 && awaited_status.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d status words outstanding",
             cycle_count, awaited_status.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
